// ===== rtl/core/owsf_pkg.sv =====
`default_nettype none

package owsf_pkg;

    localparam int DEF_SPEED_BITS      = 16;
    localparam int DEF_COEFF_FRAC_BITS = 10;

    localparam int COEFF_W    = 16;
    localparam int CFG_W      = 3 * COEFF_W;
    localparam int NUM_CFG    = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int NUM_WHEELS = 4;

    // pipeline stages, in order
    localparam int STG_SUM     = 0;
    localparam int STG_PROD    = 1;
    localparam int STG_ERR     = 2;
    localparam int STG_MUL     = 3;
    localparam int STG_SAT     = 4;
    localparam int STG_OUT     = 5;
    localparam int PIPE_STAGES = 6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BODY_COEFFS = 3'd0,
        REG_GAIN_ROW_0  = 3'd1,
        REG_GAIN_ROW_1  = 3'd2,
        REG_GAIN_ROW_2  = 3'd3,
        REG_GAIN_ROW_3  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic ld_sum;
        logic ld_prod;
        logic ld_err;
    } owsf_body_ctl_t;

    typedef struct packed {
        logic ld_mul;
        logic ld_sat;
    } owsf_lane_ctl_t;

    // width of a body velocity error; holds the error whenever the fraction width is at most 20
    function automatic int err_width(input int speed_bits, input int frac_bits);
        return speed_bits + 21 - frac_bits;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/owsf_body_est.sv =====
`default_nettype none

module owsf_body_est import owsf_pkg::*; #(
    parameter int SPEED_BITS      = DEF_SPEED_BITS,
    parameter int COEFF_FRAC_BITS = DEF_COEFF_FRAC_BITS,
    localparam int ERR_W          = err_width(SPEED_BITS, COEFF_FRAC_BITS)
) (
    input  wire logic                             aclk,
    input  wire owsf_body_ctl_t                   ctl,
    input  wire logic [3*SPEED_BITS-1:0]          target,
    input  wire logic [NUM_WHEELS*SPEED_BITS-1:0] wheel,
    input  wire logic [CFG_W-1:0]                 coeffs,
    output logic      [3*ERR_W-1:0]               err,
    output logic      [NUM_WHEELS*SPEED_BITS-1:0] wheel_out
);

    localparam int S      = SPEED_BITS;
    localparam int F      = COEFF_FRAC_BITS;
    localparam int PW     = S + 18;
    localparam int BODY_W = S + 20;
    localparam int RND_W  = BODY_W - F;
    localparam int CC_W   = COEFF_W + 1;
    localparam logic signed [CC_W-1:0]   ONE  = CC_W'(1) << F;
    localparam logic signed [BODY_W-1:0] HALF = BODY_W'(1) << (F - 1);

    logic signed [S-1:0] w [NUM_WHEELS];

    logic signed [COEFF_W-1:0] ci, cj, ck;
    logic signed [CC_W-1:0]    cj_c, ck_c;

    // stage 1: wheel sums and differences
    logic signed [S+1:0] d_cross_reg, d_cross_next;
    logic signed [S:0]   d_fdiff_reg, d_fdiff_next;
    logic signed [S:0]   d_bdiff_reg, d_bdiff_next;
    logic signed [S:0]   d_fsum_reg, d_fsum_next;
    logic signed [S:0]   d_bsum_reg, d_bsum_next;
    logic [3*S-1:0]          tgt1_reg;
    logic [NUM_WHEELS*S-1:0] whl1_reg;

    // stage 2: products
    logic signed [PW-1:0] p_x_reg, p_x_next;
    logic signed [PW-1:0] p_jf_reg, p_jf_next;
    logic signed [PW-1:0] p_jb_reg, p_jb_next;
    logic signed [PW-1:0] p_kf_reg, p_kf_next;
    logic signed [PW-1:0] p_kb_reg, p_kb_next;
    logic [3*S-1:0]          tgt2_reg;
    logic [NUM_WHEELS*S-1:0] whl2_reg;

    // stage 3: rounded body velocity and error
    logic signed [BODY_W-1:0] body [3];
    logic signed [BODY_W-1:0] body_h [3];
    logic signed [RND_W-1:0]  rnd [3];
    logic [3*ERR_W-1:0]       err_reg, err_next;
    logic [NUM_WHEELS*S-1:0]  whl3_reg;

    always_comb begin
        for (int n = 0; n < NUM_WHEELS; n++) begin
            w[n] = $signed(wheel[n*S +: S]);
        end
    end

    assign ci   = $signed(coeffs[0 +: COEFF_W]);
    assign cj   = $signed(coeffs[COEFF_W +: COEFF_W]);
    assign ck   = $signed(coeffs[2*COEFF_W +: COEFF_W]);
    assign cj_c = ONE - CC_W'(cj);
    assign ck_c = ONE - CC_W'(ck);

    always_comb begin
        d_cross_next = (S+2)'(w[2]) + (S+2)'(w[3]) - (S+2)'(w[0]) - (S+2)'(w[1]);
        d_fdiff_next = (S+1)'(w[0]) - (S+1)'(w[1]);
        d_bdiff_next = (S+1)'(w[3]) - (S+1)'(w[2]);
        d_fsum_next  = (S+1)'(w[0]) + (S+1)'(w[1]);
        d_bsum_next  = (S+1)'(w[2]) + (S+1)'(w[3]);
    end

    always_comb begin
        p_x_next  = PW'(ci)   * PW'(d_cross_reg);
        p_jf_next = PW'(cj)   * PW'(d_fdiff_reg);
        p_jb_next = PW'(cj_c) * PW'(d_bdiff_reg);
        p_kf_next = PW'(ck)   * PW'(d_fsum_reg);
        p_kb_next = PW'(ck_c) * PW'(d_bsum_reg);
    end

    always_comb begin
        body[0] = BODY_W'(p_x_reg);
        body[1] = BODY_W'(p_jf_reg) + BODY_W'(p_jb_reg);
        body[2] = BODY_W'(p_kf_reg) + BODY_W'(p_kb_reg);
        for (int n = 0; n < 3; n++) begin
            body_h[n] = body[n] + HALF;
            rnd[n]    = $signed(body_h[n][BODY_W-1:F]);
            err_next[n*ERR_W +: ERR_W] =
                ERR_W'($signed(tgt2_reg[n*S +: S])) - ERR_W'(rnd[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_sum) begin
            d_cross_reg <= d_cross_next;
            d_fdiff_reg <= d_fdiff_next;
            d_bdiff_reg <= d_bdiff_next;
            d_fsum_reg  <= d_fsum_next;
            d_bsum_reg  <= d_bsum_next;
            tgt1_reg    <= target;
            whl1_reg    <= wheel;
        end
        if (ctl.ld_prod) begin
            p_x_reg  <= p_x_next;
            p_jf_reg <= p_jf_next;
            p_jb_reg <= p_jb_next;
            p_kf_reg <= p_kf_next;
            p_kb_reg <= p_kb_next;
            tgt2_reg <= tgt1_reg;
            whl2_reg <= whl1_reg;
        end
        if (ctl.ld_err) begin
            err_reg  <= err_next;
            whl3_reg <= whl2_reg;
        end
    end

    assign err       = err_reg;
    assign wheel_out = whl3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/owsf_lane.sv =====
`default_nettype none

module owsf_lane import owsf_pkg::*; #(
    parameter int SPEED_BITS      = DEF_SPEED_BITS,
    parameter int COEFF_FRAC_BITS = DEF_COEFF_FRAC_BITS,
    localparam int ERR_W          = err_width(SPEED_BITS, COEFF_FRAC_BITS)
) (
    input  wire logic                  aclk,
    input  wire owsf_lane_ctl_t        ctl,
    input  wire logic [CFG_W-1:0]      gains,
    input  wire logic [3*ERR_W-1:0]    err,
    input  wire logic [SPEED_BITS-1:0] wheel,
    output logic      [SPEED_BITS-1:0] drive,
    output logic                       clip
);

    localparam int S     = SPEED_BITS;
    localparam int F     = COEFF_FRAC_BITS;
    localparam int MW    = ERR_W + COEFF_W;
    localparam int ACC_W = MW + 2;
    localparam int RND_W = ACC_W - F;
    localparam int RW    = RND_W + 1;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);
    localparam logic signed [RW-1:0]    SMAX = RW'({1'b0, {(S-1){1'b1}}});
    localparam logic signed [RW-1:0]    SMIN = ~SMAX;

    logic signed [MW-1:0] mul_reg [3];
    logic signed [MW-1:0] mul_next [3];
    logic [S-1:0]         whl4_reg;

    logic signed [ACC_W-1:0] acc, acc_h;
    logic signed [RND_W-1:0] rnd;
    logic signed [RW-1:0]    sum;

    logic [S-1:0] drive_reg, drive_next;
    logic         clip_reg, clip_next;

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            mul_next[n] = MW'($signed(gains[n*COEFF_W +: COEFF_W]))
                        * MW'($signed(err[n*ERR_W +: ERR_W]));
        end
    end

    always_comb begin
        acc   = ACC_W'(mul_reg[0]) + ACC_W'(mul_reg[1]) + ACC_W'(mul_reg[2]);
        acc_h = acc + HALF;
        rnd   = $signed(acc_h[ACC_W-1:F]);
        sum   = RW'(rnd) + RW'($signed(whl4_reg));
        if (sum > SMAX) begin
            drive_next = SMAX[S-1:0];
            clip_next  = 1'b1;
        end else if (sum < SMIN) begin
            drive_next = SMIN[S-1:0];
            clip_next  = 1'b1;
        end else begin
            drive_next = sum[S-1:0];
            clip_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_mul) begin
            for (int n = 0; n < 3; n++) begin
                mul_reg[n] <= mul_next[n];
            end
            whl4_reg <= wheel;
        end
        if (ctl.ld_sat) begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign drive = drive_reg;
    assign clip  = clip_reg;

endmodule

`default_nettype wire

// ===== rtl/core/omni_wheel_speed_feedforward_unit.sv =====
//  channel  | ports                    | carries
//  ---------+--------------------------+--------------------------------------------
//  input    | s_tvalid s_tready s_tdata | target vx, vy, omega, wheel speeds 0..3
//  result   | m_tvalid m_tready m_tdata | drive speeds 0..3, m_tuser = clipped
//  config   | cfg_we cfg_addr cfg_wdata | coefficient i/j/k word, gain rows 0..3
//
//  six-stage pipeline, one transfer per cycle in and out while m_tready stays high
//  sums, body multiplies, body error, four lane multiplies, lane saturate, output register
//  each stage holds its item until the next stage frees, so a stalled output
//  still takes new items until every stage is full
//  aresetn clears the pipeline valid bits and the five configuration registers to zero
`default_nettype none

module omni_wheel_speed_feedforward_unit import owsf_pkg::*; #(
    parameter int SPEED_BITS      = DEF_SPEED_BITS,
    parameter int COEFF_FRAC_BITS = DEF_COEFF_FRAC_BITS,
    localparam int IN_W           = ((7 * SPEED_BITS + 7) / 8) * 8,
    localparam int OUT_W          = ((NUM_WHEELS * SPEED_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // target_vx, target_vy, target_omega, wheel_speed_0..3
    input  wire logic [IN_W-1:0]       s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // drive_speed_0..3
    output logic      [OUT_W-1:0]      m_tdata,
    // clipped
    output logic                       m_tuser,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int S     = SPEED_BITS;
    localparam int ERR_W = err_width(SPEED_BITS, COEFF_FRAC_BITS);

    logic [CFG_W-1:0] cfg_reg  [NUM_CFG];
    logic [CFG_W-1:0] cfg_next [NUM_CFG];

    logic [PIPE_STAGES-1:0] vld_reg, vld_next;
    logic [PIPE_STAGES-1:0] rdy, ld;

    owsf_body_ctl_t body_ctl;
    owsf_lane_ctl_t lane_ctl;

    logic [3*ERR_W-1:0]      err;
    logic [NUM_WHEELS*S-1:0] whl_err;
    logic [NUM_WHEELS*S-1:0] drive_cat;
    logic [NUM_WHEELS-1:0]   lane_clip;

    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_clip_reg, out_clip_next;

    // configuration registers
    always_comb begin
        for (int n = 0; n < NUM_CFG; n++) begin
            cfg_next[n] = cfg_reg[n];
        end
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_BODY_COEFFS: cfg_next[0] = cfg_wdata;
                REG_GAIN_ROW_0:  cfg_next[1] = cfg_wdata;
                REG_GAIN_ROW_1:  cfg_next[2] = cfg_wdata;
                REG_GAIN_ROW_2:  cfg_next[3] = cfg_wdata;
                REG_GAIN_ROW_3:  cfg_next[4] = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_CFG; n++) begin
                cfg_reg[n] <= '0;
            end
        end else begin
            for (int n = 0; n < NUM_CFG; n++) begin
                cfg_reg[n] <= cfg_next[n];
            end
        end
    end

    // pipeline flow control
    always_comb begin
        rdy[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || m_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0]       = s_tvalid && rdy[0];
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            ld[k]       = vld_reg[k-1] && rdy[k];
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign body_ctl.ld_sum  = ld[STG_SUM];
    assign body_ctl.ld_prod = ld[STG_PROD];
    assign body_ctl.ld_err  = ld[STG_ERR];
    assign lane_ctl.ld_mul  = ld[STG_MUL];
    assign lane_ctl.ld_sat  = ld[STG_SAT];

    owsf_body_est #(
        .SPEED_BITS      (SPEED_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_body (
        .aclk      (aclk),
        .ctl       (body_ctl),
        .target    (s_tdata[0 +: 3*S]),
        .wheel     (s_tdata[3*S +: NUM_WHEELS*S]),
        .coeffs    (cfg_reg[0]),
        .err       (err),
        .wheel_out (whl_err)
    );

    for (genvar n = 0; n < NUM_WHEELS; n++) begin : g_lane
        owsf_lane #(
            .SPEED_BITS      (SPEED_BITS),
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_lane (
            .aclk  (aclk),
            .ctl   (lane_ctl),
            .gains (cfg_reg[1+n]),
            .err   (err),
            .wheel (whl_err[n*S +: S]),
            .drive (drive_cat[n*S +: S]),
            .clip  (lane_clip[n])
        );
    end

    // merge lanes into the output register
    assign out_data_next = OUT_W'(drive_cat);
    assign out_clip_next = |lane_clip;

    always_ff @(posedge aclk) begin
        if (ld[STG_OUT]) begin
            out_data_reg <= out_data_next;
            out_clip_reg <= out_clip_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input blocked while a pipeline stage is empty");

    a_sat_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[STG_SAT] && rdy[STG_OUT]) |=> vld_reg[STG_OUT])
        else $error("lane result lost on its way to the output register");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
